[rtl/isort_pkg.sv]
package isort_pkg;

    localparam int ITEM_W          = 32;
    localparam int STORE_DEPTH_DEF = 32;

    // controller to datapath
    typedef struct packed {
        logic insert;   // insert the accepted value, or mark overflow when full
        logic drain;    // move cell 0 to the output register and shift the row down
        logic restart;  // clear the overflow mark for the next set
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;
    } t_dp_sts;

endpackage

[rtl/insertion_sort_engine.sv]
// Insertion sorter for sets of signed 32-bit values. Each input transaction
// carries one value on tdata, with tlast on the last value of a set. A row of
// STORE_DEPTH compare-and-shift cells places every value after all held
// values less than or equal to it, so equal values keep arrival order; the
// input takes a new value while a set is loading. After the tlast
// transaction the input stalls while the set drains from the bottom cell,
// one result per cycle while the output is not stalled, with tlast on the
// largest value. Values beyond STORE_DEPTH are dropped and every result of
// that set then carries tuser[0] high.
module insertion_sort_engine #(
    parameter int STORE_DEPTH = isort_pkg::STORE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] item_value
    input  logic        i_s_tlast,   // set_end
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] sorted_value
    output logic        o_m_tlast,   // final_out
    output logic [0:0]  o_m_tuser    // [0] dropped_flag
);
    import isort_pkg::*;

    t_dp_cmd                  w_cmd;
    t_dp_sts                  w_sts;
    logic signed [ITEM_W-1:0] w_out_value;
    logic                     w_out_drop;

    isort_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    isort_datapath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_value (signed'(i_s_tdata)),
        .o_sts   (w_sts),
        .o_value (w_out_value),
        .o_last  (o_m_tlast),
        .o_drop  (w_out_drop)
    );

    assign o_m_tdata    = unsigned'(w_out_value);
    assign o_m_tuser[0] = w_out_drop;

endmodule

[rtl/isort_datapath.sv]
module isort_datapath #(
    parameter int STORE_DEPTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  isort_pkg::t_dp_cmd                  i_cmd,
    input  logic signed [isort_pkg::ITEM_W-1:0] i_value,
    output isort_pkg::t_dp_sts                  o_sts,
    output logic signed [isort_pkg::ITEM_W-1:0] o_value,
    output logic                                o_last,
    output logic                                o_drop
);
    import isort_pkg::*;

    localparam int CNT_W = $clog2(STORE_DEPTH + 1);

    logic signed [ITEM_W-1:0] r_cell [STORE_DEPTH];
    logic signed [ITEM_W-1:0] n_cell [STORE_DEPTH];
    logic        [CNT_W-1:0]  r_count;
    logic                     r_ovf;
    logic signed [ITEM_W-1:0] r_out_value;
    logic                     r_out_last;
    logic                     r_out_drop;
    logic [STORE_DEPTH-1:0]   w_gt;
    logic                     w_full;

    assign w_full = (r_count == CNT_W'(STORE_DEPTH));

    // Each held cell compares its value against the incoming one; the flags run
    // false then true along the held cells, and cells past the count read false.
    always_comb begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            w_gt[i] = (CNT_W'(i) < r_count) && (r_cell[i] > i_value);
        end
    end

    always_comb begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            n_cell[i] = r_cell[i];
            if (i_cmd.drain) begin
                if (i < STORE_DEPTH - 1) begin
                    n_cell[i] = r_cell[(i + 1) % STORE_DEPTH];
                end
            end else if (i_cmd.insert && !w_full && CNT_W'(i) <= r_count) begin
                if (i > 0 && w_gt[(i + STORE_DEPTH - 1) % STORE_DEPTH]) begin
                    n_cell[i] = r_cell[(i + STORE_DEPTH - 1) % STORE_DEPTH];
                end else if (w_gt[i] || CNT_W'(i) == r_count) begin
                    n_cell[i] = i_value;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
        if (i_cmd.drain) begin
            r_out_value <= r_cell[0];
            r_out_last  <= (r_count == CNT_W'(1));
            r_out_drop  <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cmd.insert) begin
                if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CNT_W'(1);
                end
            end else if (i_cmd.drain) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.restart) begin
                r_ovf <= 1'b0;
            end
        end
    end

    assign o_sts.empty = (r_count == '0);
    assign o_value     = r_out_value;
    assign o_last      = r_out_last;
    assign o_drop      = r_out_drop;

endmodule

[rtl/isort_ctrl.sv]
module isort_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    input  logic               i_s_tlast,
    output logic               o_s_tready,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    input  isort_pkg::t_dp_sts i_sts,
    output isort_pkg::t_dp_cmd o_cmd
);
    import isort_pkg::*;

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;
    logic   w_in_acc;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_in_acc   = i_s_tvalid && (r_state == ST_FILL);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_m_tready;
        o_cmd       = '0;
        unique case (r_state)
            ST_FILL: begin
                if (w_in_acc) begin
                    o_cmd.insert = 1'b1;
                    if (i_s_tlast) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (i_sts.empty) begin
                    o_cmd.restart = 1'b1;
                    n_state       = ST_FILL;
                end else if (w_out_free) begin
                    o_cmd.drain = 1'b1;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == ST_FILL);
    assign o_m_tvalid = r_out_valid;

endmodule

[dv/insertion_sort_engine_tb.sv]
module insertion_sort_engine_tb;

    import isort_pkg::*;

    localparam int DEPTH       = STORE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_ITEMS  = 88;

    localparam logic [ITEM_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [ITEM_W-1:0] VAL_MAX = 32'h7fff_ffff;

    typedef struct packed {
        logic [ITEM_W-1:0] value;
        logic              set_end;
    } t_sort_item;

    typedef struct packed {
        logic [ITEM_W-1:0] value;
        logic              final_out;
        logic              dropped;
    } t_sorted_result;

    logic              i_clk      = 1'b0;
    logic              rst_n      = 1'b0;
    logic              s_tvalid   = 1'b0;
    logic [ITEM_W-1:0] s_tdata    = '0;
    logic              s_tlast    = 1'b0;
    logic              m_tready   = 1'b0;
    logic              o_s_tready;
    logic              o_m_tvalid;
    logic [ITEM_W-1:0] o_m_tdata;
    logic              o_m_tlast;
    logic [0:0]        o_m_tuser;

    t_sort_item        pending_items[$];
    t_sorted_result    expected_results[$];
    logic [ITEM_W-1:0] held_values[$];
    logic              set_dropped = 1'b0;

    int error_count = 0;
    int cycle_count = 0;
    int in_taken    = 0;
    int in_seen     = 0;
    int out_taken   = 0;
    int out_seen    = 0;
    int in_gap      = 0;
    int in_calm     = 0;
    int out_stall   = 0;
    int out_calm    = 0;

    insertion_sort_engine #(
        .STORE_DEPTH(DEPTH)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (s_tdata),    // [31:0] item_value
        .i_s_tlast (s_tlast),    // set_end
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (o_m_tdata),  // [31:0] sorted_value
        .o_m_tlast (o_m_tlast),  // final_out
        .o_m_tuser (o_m_tuser)   // [0] dropped_flag
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Idle cycles before the next transaction; now and then a run of items with no idling.
    function automatic int pick_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 12) == 0)
            calm = $urandom_range(4, 24);
        return $urandom_range(0, 11);
    endfunction

    function automatic logic [ITEM_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom;
            5, 6:          return $urandom_range(0, 8) - 4;
            7:             return VAL_MIN + $urandom_range(0, 2);
            8:             return VAL_MAX - $urandom_range(0, 2);
            default:       return $urandom_range(0, 1000);
        endcase
    endfunction

    task automatic queue_item(input logic [ITEM_W-1:0] value, input logic set_end);
        t_sort_item item;
        item.value   = value;
        item.set_end = set_end;
        pending_items.push_back(item);
    endtask

    task automatic queue_random_set(input int len);
        for (int k = 0; k < len; k++)
            queue_item(pick_value(), k == len - 1);
    endtask

    // Insert after every held value <= the new one; emit the whole set on set_end.
    task automatic absorb_item(input logic [ITEM_W-1:0] value, input logic set_end);
        int             pos;
        t_sorted_result res;
        if (held_values.size() < DEPTH) begin
            pos = 0;
            while (pos < held_values.size() && $signed(held_values[pos]) <= $signed(value))
                pos++;
            held_values.insert(pos, value);
        end else begin
            set_dropped = 1'b1;
        end
        if (set_end) begin
            for (int k = 0; k < held_values.size(); k++) begin
                res.value     = held_values[k];
                res.final_out = (k == held_values.size() - 1);
                res.dropped   = set_dropped;
                expected_results.push_back(res);
            end
            held_values.delete();
            set_dropped = 1'b0;
        end
    endtask

    always @(negedge i_clk) begin : item_driver
        logic              nxt_valid;
        logic [ITEM_W-1:0] nxt_data;
        logic              nxt_last;
        t_sort_item        item;
        nxt_valid = s_tvalid;
        nxt_data  = s_tdata;
        nxt_last  = s_tlast;
        if (rst_n) begin
            if (s_tvalid && in_taken != in_seen) begin
                in_seen   = in_taken;
                nxt_valid = 1'b0;
                in_gap    = pick_wait(in_calm);
            end
            if (!nxt_valid) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pending_items.size() > 0) begin
                    item      = pending_items.pop_front();
                    nxt_valid = 1'b1;
                    nxt_data  = item.value;
                    nxt_last  = item.set_end;
                end
            end
        end
        s_tvalid <= nxt_valid;
        s_tdata  <= nxt_data;
        s_tlast  <= nxt_last;
    end

    always @(negedge i_clk) begin : result_sink
        logic nxt_ready;
        nxt_ready = m_tready;
        if (rst_n) begin
            // stall before the next result once a transaction completes
            if (m_tready && out_taken != out_seen) begin
                out_seen  = out_taken;
                nxt_ready = 1'b0;
                out_stall = pick_wait(out_calm);
            end
            if (!nxt_ready) begin
                if (out_stall > 0)
                    out_stall--;
                else
                    nxt_ready = 1'b1;
            end
        end
        m_tready <= nxt_ready;
    end

    always @(posedge i_clk) begin : monitor
        t_sorted_result want;
        if (rst_n) begin
            if (o_m_tvalid && m_tready) begin
                out_taken++;
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result: expected none, got value %h last %b drop %b",
                             $time, o_m_tdata, o_m_tlast, o_m_tuser[0]);
                end else begin
                    want = expected_results.pop_front();
                    if (o_m_tdata !== want.value) begin
                        error_count++;
                        $display("%0t: sorted_value mismatch: expected %h, got %h",
                                 $time, want.value, o_m_tdata);
                    end
                    if (o_m_tlast !== want.final_out) begin
                        error_count++;
                        $display("%0t: final_out mismatch: expected %b, got %b",
                                 $time, want.final_out, o_m_tlast);
                    end
                    if (o_m_tuser[0] !== want.dropped) begin
                        error_count++;
                        $display("%0t: dropped_flag mismatch: expected %b, got %b",
                                 $time, want.dropped, o_m_tuser[0]);
                    end
                end
            end
            if (s_tvalid && o_s_tready) begin
                in_taken++;
                absorb_item(s_tdata, s_tlast);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        int rand_count;
        int set_idx;
        int len;

        // single-value sets at both extremes
        queue_item(VAL_MIN, 1'b1);
        queue_item(VAL_MAX, 1'b1);
        // mixed signs, duplicates, extremes in the middle of a set
        queue_item(32'd0, 1'b0);
        queue_item(32'hffff_ffff, 1'b0);
        queue_item(32'd1, 1'b0);
        queue_item(VAL_MAX, 1'b0);
        queue_item(VAL_MIN, 1'b0);
        queue_item(32'd5, 1'b0);
        queue_item(32'd5, 1'b0);
        queue_item(-32'sd5, 1'b0);
        queue_item(32'd0, 1'b1);
        // already ascending
        queue_item(32'd1, 1'b0);
        queue_item(32'd2, 1'b0);
        queue_item(32'd3, 1'b0);
        queue_item(32'd4, 1'b1);
        // descending
        queue_item(VAL_MAX, 1'b0);
        queue_item(32'd100, 1'b0);
        queue_item(-32'sd100, 1'b0);
        queue_item(VAL_MIN, 1'b1);
        // all equal
        queue_item(32'd7, 1'b0);
        queue_item(32'd7, 1'b0);
        queue_item(32'd7, 1'b1);

        // mostly short sets; one that fills the store exactly, one that overflows
        // on a middle item and on the tlast item
        rand_count = 0;
        set_idx    = 0;
        while (rand_count < RAND_ITEMS) begin
            case (set_idx)
                1:       len = DEPTH;
                3:       len = DEPTH + 2;
                default: len = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 20)
                                                           : $urandom_range(1, 6);
            endcase
            queue_random_set(len);
            rand_count += len;
            set_idx++;
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        rst_n = 1'b1;

        // hold until every item is in and every result is out
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (DEPTH + 8) @(negedge i_clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
rtl/isort_pkg.sv
rtl/isort_datapath.sv
rtl/isort_ctrl.sv
rtl/insertion_sort_engine.sv
dv/insertion_sort_engine_tb.sv
